// ===== sv/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the maximum subarray segment tree.
// ----------------------------------------------------------------------------
`default_nettype none
package mss_pkg;
	localparam int unsigned LEAVES_DEF = 1024;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned VAL_W      = 16;
	localparam int unsigned SUM_W      = 32;

	localparam logic CMD_SET   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        last_index;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] answer;
		logic                    range_error;
	} out_item_t;

	// node summary as stored in memory
	typedef struct packed {
		logic signed [SUM_W-1:0] pre;
		logic signed [SUM_W-1:0] suf;
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] span;
		logic signed [VAL_W-1:0] top;
	} node_t;

	function automatic logic signed [SUM_W-1:0] smax(
		input logic signed [SUM_W-1:0] a, input logic signed [SUM_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// combine a left span with the span to its right
	function automatic node_t join_nodes(input node_t a, input node_t b);
		node_t r;
		r.pre  = smax(a.pre, a.sum + b.pre);
		r.suf  = smax(b.suf, a.suf + b.sum);
		r.span = smax(smax(a.span, b.span), a.suf + b.pre);
		r.sum  = a.sum + b.sum;
		r.top  = (a.top > b.top) ? a.top : b.top;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/max_subarray_segment_tree.sv =====
// ----------------------------------------------------------------------------
// max_subarray_segment_tree
// Segment tree over signed leaves answering best subarray sum queries.
// ----------------------------------------------------------------------------
// Input channel (in_item, in_valid, in_stall): cmd 0 sets one leaf and walks
// its path to the root, giving no result; cmd 1 queries the inclusive range
// first_index..last_index and gives one result item on the output channel
// (out_item, out_valid, out_stall).
// Nodes live in one synchronous memory with one read port; every node read
// passes through a registered read port. An update writes the leaf, then per
// level does two sibling reads, a wait for the second read and one write of
// the parent; a query does a step and a wait per covering node read, and one
// step per level climbed.
// Reversed ranges finish without any memory read. One item is worked at a time.
// The result sits in an output register; the next item is taken while it
// waits, but finishing a query waits for that register to empty.
// After reset the block sweeps all 2*LEAVES nodes to zero, one node a cycle,
// during which in_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none
module max_subarray_segment_tree #(
	parameter int unsigned LEAVES = mss_pkg::LEAVES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mss_pkg::in_item_t  in_item,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output mss_pkg::out_item_t    out_item,
	output logic                  out_valid,
	input  wire logic             out_stall
);
	import mss_pkg::*;

	localparam int unsigned LW = $clog2(LEAVES);
	localparam int unsigned AW = LW + 1;
	localparam int unsigned XW = ((IDX_W > AW) ? IDX_W : AW) + 1;
	localparam int unsigned DEPTH = 2 * LEAVES;
	localparam logic [XW-1:0] LEAVES_X = XW'(LEAVES);
	localparam logic [XW-1:0] LAST_X = XW'(LEAVES - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_URD_A, ST_URD_B, ST_UWAIT, ST_UWR,
		ST_QSTEP, ST_QWAIT, ST_QDONE
	} state_t;

	state_t state_q;
	node_t mem [DEPTH];
	node_t rd_data_s1;

	logic [AW-1:0] clr_q, p_q, rd_addr;
	logic [XW-1:0] l_q, r_q;
	logic          rd_en;
	logic          we;
	logic [AW-1:0] wr_addr;
	node_t         wr_data;
	node_t         a_q, left_q, right_q;
	logic          lv_q, rv_q, side_q;
	logic signed [SUM_W-1:0] ans_q;
	logic          err_q;
	out_item_t     res_q;
	logic          res_v_q;

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

	// extend fields to tree addresses
	logic [XW-1:0] first_x, last_x, last_sat;
	logic [AW-1:0] leaf_addr;
	logic          set_ok;
	assign first_x   = XW'(in_item.first_index);
	assign last_x    = XW'(in_item.last_index);
	assign last_sat  = (last_x > LAST_X) ? LAST_X : last_x;
	assign set_ok    = first_x < LEAVES_X;
	assign leaf_addr = AW'(first_x + LEAVES_X);

	node_t leaf_n, joined;
	always_comb begin
		leaf_n.sum  = SUM_W'(in_item.value);
		leaf_n.pre  = (in_item.value > 0) ? leaf_n.sum : '0;
		leaf_n.suf  = leaf_n.pre;
		leaf_n.span = leaf_n.pre;
		leaf_n.top  = in_item.value;
	end
	assign joined = join_nodes(a_q, rd_data_s1);

	// query combine of fresh node into the left or right accumulator
	node_t left_nx, right_nx, all_n;
	always_comb begin
		left_nx  = lv_q ? join_nodes(left_q, rd_data_s1) : rd_data_s1;
		right_nx = rv_q ? join_nodes(rd_data_s1, right_q) : rd_data_s1;
		if (!lv_q) all_n = right_q;
		else if (!rv_q) all_n = left_q;
		else all_n = join_nodes(left_q, right_q);
	end

	// next query read: left node when odd, else right node when odd
	logic [XW-1:0] r_dec;
	assign r_dec = r_q - XW'(1);

	assign in_stall = (state_q != ST_IDLE);

	// memory port control
	always_comb begin
		we = 1'b0; wr_addr = p_q; wr_data = joined;
		rd_en = 1'b0; rd_addr = {p_q[AW-1:1], 1'b0};
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1; wr_addr = clr_q; wr_data = '0;
			end
			ST_IDLE: begin
				we = in_valid && in_item.cmd == CMD_SET && set_ok;
				wr_addr = leaf_addr; wr_data = leaf_n;
			end
			ST_URD_A: begin
				rd_en = 1'b1; rd_addr = {p_q[AW-1:1], 1'b0};
			end
			ST_URD_B: begin
				rd_en = 1'b1; rd_addr = {p_q[AW-1:1], 1'b1};
			end
			ST_UWR: begin
				we = 1'b1; wr_addr = {1'b0, p_q[AW-1:1]}; wr_data = joined;
			end
			ST_QSTEP: begin
				rd_en = 1'b1;
				rd_addr = AW'(l_q[0] ? l_q : r_dec);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0; res_v_q <= 1'b0;
			lv_q <= 1'b0; rv_q <= 1'b0; side_q <= 1'b0;
			p_q <= '0; l_q <= '0; r_q <= '0;
			a_q <= '0; left_q <= '0; right_q <= '0;
			ans_q <= '0; err_q <= 1'b0; res_q <= '0;
		end else begin
			// load the output register when free, drop it once taken
			if (state_q == ST_QDONE && (!res_v_q || !out_stall)) begin
				res_v_q <= 1'b1;
			end else if (res_v_q && !out_stall) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) begin
					if (in_item.cmd == CMD_SET) begin
						p_q <= leaf_addr;
						if (set_ok) state_q <= ST_URD_A;
					end else begin
						lv_q <= 1'b0; rv_q <= 1'b0;
						l_q <= first_x + LEAVES_X;
						r_q <= last_sat + XW'(1) + LEAVES_X;
						ans_q <= '0;
						err_q <= first_x > last_sat;
						state_q <= (first_x > last_sat) ? ST_QDONE : ST_QSTEP;
					end
				end
				ST_URD_A: state_q <= ST_URD_B;
				ST_URD_B: begin
					a_q <= rd_data_s1; state_q <= ST_UWAIT;
				end
				ST_UWAIT: state_q <= ST_UWR;
				ST_UWR: begin
					p_q <= {1'b0, p_q[AW-1:1]};
					state_q <= (p_q[AW-1:1] == (AW-1)'(1)) ? ST_IDLE : ST_URD_A;
				end
				ST_QSTEP: begin
					if (l_q >= r_q) begin
						ans_q <= (all_n.top < 0) ? SUM_W'(all_n.top) : all_n.span;
						state_q <= ST_QDONE;
					end else if (l_q[0]) begin
						side_q <= 1'b0; l_q <= l_q + XW'(1); state_q <= ST_QWAIT;
					end else if (r_q[0]) begin
						side_q <= 1'b1; r_q <= r_dec; state_q <= ST_QWAIT;
					end else begin
						l_q <= l_q >> 1; r_q <= r_q >> 1;
					end
				end
				ST_QWAIT: begin
					if (side_q) begin
						right_q <= right_nx; rv_q <= 1'b1;
					end else begin
						left_q <= left_nx; lv_q <= 1'b1;
					end
					state_q <= ST_QSTEP;
				end
				ST_QDONE: if (!res_v_q || !out_stall) begin
					res_q.answer <= ans_q;
					res_q.range_error <= err_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_item  = res_q;
	assign out_valid = res_v_q;

	// checks
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall) else $error("item taken during clear");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.range_error |-> out_item.answer == '0)
		else $error("range error with nonzero answer");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result lost");
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item)) else $error("stalled item changed");
endmodule
`default_nettype wire

// ===== sim/max_subarray_segment_tree_tb.sv =====
// ----------------------------------------------------------------------------
// max_subarray_segment_tree_tb
// Drives leaf updates and range queries into the segment tree, predicts query
// answers from a private copy of the leaves or takes a typed-in answer, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module max_subarray_segment_tree_tb;
	import mss_pkg::*;

	localparam int NLEAF = 1024;
	localparam int RAND_ITEMS = 950;

	logic clk;
	logic arst_n;
	in_item_t in_item;
	logic in_valid;
	logic in_stall;
	out_item_t out_item;
	logic out_valid;
	logic out_stall;

	max_subarray_segment_tree #(.LEAVES(NLEAF)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_item), .in_valid(in_valid), .in_stall(in_stall),
		.out_item(out_item), .out_valid(out_valid), .out_stall(out_stall)
	);

	// directed row: item plus optional typed-in answer
	typedef struct {
		in_item_t item;
		bit       known;
		out_item_t answer;
	} row_t;

	logic signed [VAL_W-1:0] leaf_val [NLEAF];
	out_item_t answer_q [$];
	int mismatches;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// best subarray over leaf_val[lo..hi] by Kadane, with the negative-max rule
	function automatic out_item_t best_range(input in_item_t it);
		out_item_t r;
		int lo, hi;
		longint run, best, top;
		lo = it.first_index;
		hi = (it.last_index >= NLEAF) ? NLEAF - 1 : it.last_index;
		r.range_error = 1'b0;
		r.answer = '0;
		if (lo > hi) begin
			r.range_error = 1'b1;
			return r;
		end
		run = 0; best = 0; top = -65536;
		for (int i = lo; i <= hi; i++) begin
			run = run + leaf_val[i];
			if (run < 0) run = 0;
			if (run > best) best = run;
			if (leaf_val[i] > top) top = leaf_val[i];
		end
		r.answer = SUM_W'((top < 0) ? top : best);
		return r;
	endfunction

	function automatic in_item_t mk(input logic c, input int f, input int l, input int v);
		in_item_t it;
		it.cmd = c;
		it.first_index = IDX_W'(f);
		it.last_index = IDX_W'(l);
		it.value = VAL_W'(v);
		return it;
	endfunction

	// accept one item with a full handshake
	task automatic send_item(input in_item_t it, input bit known, input out_item_t ans);
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (it.cmd == CMD_QUERY) begin
			answer_q.push_back(known ? ans : best_range(it));
		end else begin
			leaf_val[it.first_index] = it.value;
		end
		@(negedge clk);
	endtask

	task automatic gap();
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// receiver stall pattern: phases of free flow, of light stalling and of heavy stalling
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(10, 60)) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d err %0b",
					out_item.answer, out_item.range_error);
			end else begin
				exp_r = answer_q.pop_front();
				if (exp_r.answer !== out_item.answer
						|| exp_r.range_error !== out_item.range_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d err %0b, got %0d err %0b",
							exp_r.answer, exp_r.range_error,
							out_item.answer, out_item.range_error);
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		out_item_t none;
		in_item_t it;
		int burst, pick, a, b, w;
		none = '0;
		mismatches = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		for (int i = 0; i < NLEAF; i++) leaf_val[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed table: zero tree, reversed ranges, extremes
		rw.known = 1; rw.answer = '0;
		rw.item = mk(CMD_QUERY, 0, 1023, 0); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 5, 5, 0); rows.push_back(rw);
		rw.answer.range_error = 1'b1;
		rw.item = mk(CMD_QUERY, 1023, 0, -1); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 7, 6, 0); rows.push_back(rw);
		rw.known = 0;
		rw.item = mk(CMD_SET, 0, 1023, 32767); rows.push_back(rw);
		rw.item = mk(CMD_SET, 1023, 0, -32768); rows.push_back(rw);
		rw.item = mk(CMD_SET, 1, 0, -32768); rows.push_back(rw);
		rw.item = mk(CMD_SET, 512, 0, -1); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 0, 1023, 0); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 1023, 1023, 0); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 1, 1, 0); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 512, 512, 0); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 1, 0, 0); rows.push_back(rw);
		for (int i = 0; i < 8; i++) begin
			rw.item = mk(CMD_SET, 100 + i, 0, -32768); rows.push_back(rw);
		end
		rw.item = mk(CMD_QUERY, 100, 107, 0); rows.push_back(rw);
		rw.item = mk(CMD_SET, 104, 0, 32767); rows.push_back(rw);
		rw.item = mk(CMD_QUERY, 99, 108, 0); rows.push_back(rw);
		foreach (rows[i]) begin
			send_item(rows[i].item, rows[i].known, rows[i].answer);
			gap();
		end

		// random bursts: mostly updates and queries over short windows
		pick = 0;
		while (pick < RAND_ITEMS) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst; k++) begin
				it.cmd = CMD_SET;
				it.first_index = IDX_W'($urandom);
				it.last_index = IDX_W'($urandom);
				it.value = VAL_W'($urandom);
				w = $urandom_range(0, 9);
				if (w < 5) begin
					it.cmd = CMD_SET;
					if ($urandom_range(0, 1))
						it.first_index = IDX_W'($urandom_range(96, 160));
				end else begin
					it.cmd = CMD_QUERY;
					a = $urandom_range(0, 1023);
					if (w < 9) begin
						a = $urandom_range(80, 170);
						b = a + $urandom_range(0, 40);
					end else begin
						b = $urandom_range(0, 1023);
					end
					it.first_index = IDX_W'(a);
					it.last_index = IDX_W'((b > 1023) ? 1023 : b);
				end
				send_item(it, 0, none);
				pick++;
			end
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
		in_valid <= 1'b0;

		while (answer_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// end the run if the block hangs
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
